@@ rtl/core/whf_pkg.sv @@
// Shared types and constants for the waypoint heading follower.
// Used by whf_cordic, the top level and whf_checker; depends on nothing else.
package whf_pkg;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_ODOM = 1'b1;

	localparam logic [2:0] PH_TURN  = 3'd0;
	localparam logic [2:0] PH_DRIVE = 3'd1;
	localparam logic [2:0] PH_STOP  = 3'd2;
	localparam logic [2:0] PH_DONE  = 3'd3;
	localparam logic [2:0] PH_EMPTY = 3'd4;

	localparam logic [2:0] REG_POS_TOL  = 3'd0;
	localparam logic [2:0] REG_HEAD_TOL = 3'd1;
	localparam logic [2:0] REG_GAIN     = 3'd2;
	localparam logic [2:0] REG_CRUISE   = 3'd3;
	localparam logic [2:0] REG_SETTLE   = 3'd4;

	typedef enum logic [11:0] {
		ST_IDLE = 12'b0000_0000_0001,
		ST_DIFF = 12'b0000_0000_0010,
		ST_SQX  = 12'b0000_0000_0100,
		ST_SQY  = 12'b0000_0000_1000,
		ST_TOL  = 12'b0000_0001_0000,
		ST_CORD = 12'b0000_0010_0000,
		ST_ERR  = 12'b0000_0100_0000,
		ST_GAIN = 12'b0000_1000_0000,
		ST_VX   = 12'b0001_0000_0000,
		ST_VY   = 12'b0010_0000_0000,
		ST_SET  = 12'b0100_0000_0000,
		ST_DONE = 12'b1000_0000_0000
	} whf_state_t;

	// Start request for the heading unit: offset from robot to waypoint.
	typedef struct packed {
		logic               start;
		logic signed [16:0] dx;
		logic signed [16:0] dy;
	} whf_cordic_req_t;

	// atan(2^-i) with pi = 2^31.
	function automatic logic [31:0] atan_tab(input logic [4:0] i);
		logic [31:0] v;
		case (i)
			5'd0:  v = 32'd536870912;
			5'd1:  v = 32'd316933406;
			5'd2:  v = 32'd167458907;
			5'd3:  v = 32'd85004756;
			5'd4:  v = 32'd42667331;
			5'd5:  v = 32'd21354465;
			5'd6:  v = 32'd10679838;
			5'd7:  v = 32'd5340245;
			5'd8:  v = 32'd2670163;
			5'd9:  v = 32'd1335087;
			5'd10: v = 32'd667544;
			5'd11: v = 32'd333772;
			5'd12: v = 32'd166886;
			5'd13: v = 32'd83443;
			5'd14: v = 32'd41722;
			5'd15: v = 32'd20861;
			5'd16: v = 32'd10430;
			5'd17: v = 32'd5215;
			5'd18: v = 32'd2608;
			5'd19: v = 32'd1304;
			5'd20: v = 32'd652;
			5'd21: v = 32'd326;
			5'd22: v = 32'd163;
			5'd23: v = 32'd81;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

@@ rtl/core/whf_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module whf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/whf_cordic.sv @@
// Iterative CORDIC atan2, one micro-rotation per cycle.
// Depends on whf_pkg for the request struct and the arctangent table.
module whf_cordic #(
	parameter int STEPS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  whf_pkg::whf_cordic_req_t req,
	output logic                     done,
	output logic [15:0]              head
);

	localparam int SW = $clog2(STEPS);
	localparam int XW = 28;

	logic signed [XW-1:0] x_q, y_q, x0, y0, xs, ys;
	logic [31:0]          z_q, z0, z_rnd;
	logic [SW-1:0]        i_q;
	logic                 busy_q, done_q;

	// Offsets are scaled by 256 for resolution; the left half plane is rotated
	// by a quarter turn first so the iterations always converge.
	always_comb begin
		logic signed [XW-1:0] sx, sy;
		sx = {{(XW-25){req.dx[16]}}, req.dx, 8'b0};
		sy = {{(XW-25){req.dy[16]}}, req.dy, 8'b0};
		x0 = sx;
		y0 = sy;
		z0 = 32'h0000_0000;
		if (sx < 0) begin
			if (sy >= 0) begin
				x0 = sy;
				y0 = -sx;
				z0 = 32'h4000_0000;
			end else begin
				x0 = -sy;
				y0 = sx;
				z0 = 32'hC000_0000;
			end
		end
	end

	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				if (i_q == SW'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					i_q <= i_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q <= x0;
			y_q <= y0;
			z_q <= z0;
		end else if (busy_q) begin
			if (y_q >= 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + whf_pkg::atan_tab(5'(i_q));
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - whf_pkg::atan_tab(5'(i_q));
			end
		end
	end

	assign z_rnd = z_q + 32'h0000_8000;
	assign head  = z_rnd[31:16];
	assign done  = done_q;

endmodule

@@ rtl/core/waypoint_heading_follower.sv @@
// Waypoint follower: turn toward the current waypoint, drive to it, stop, advance.
// A load word is taken while idle and yields nothing. An odometry word yields one
// command: an empty or finished list goes straight to the result; otherwise the
// distance check runs on the single shared multiplier, then the settle check when
// stopping or the iterative CORDIC when driving or turning. One word is in work at a time.
// Reset (arst_n, asynchronous) empties the list and restores register defaults.
module waypoint_heading_follower #(
	parameter int MAX_WAYPOINTS = 16,
	parameter int CORDIC_STEPS  = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               opcode,
	input  logic               restart,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic signed [15:0] yaw,
	input  logic signed [15:0] vel_x,
	input  logic signed [15:0] vel_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [15:0]        linear_cmd,
	output logic signed [15:0] angular_cmd,
	output logic [4:0]         target_index,
	output logic [2:0]         phase,
	output logic               reached
);

	localparam int CW = $clog2(MAX_WAYPOINTS + 1);
	localparam int AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;

	whf_pkg::whf_state_t state_q;

	logic [15:0] pos_tol_q, gain_q, cruise_q, settle_q;
	logic [14:0] head_tol_q;
	logic [CW-1:0] count_q, idx_q, base;
	logic [CW+4:0] idx_ext;

	logic signed [15:0] px_q, py_q, yaw_q, vx_q, vy_q;
	logic signed [16:0] dx_q, dy_q;
	logic [33:0]        acc_q;
	logic               err_neg_q;
	logic [16:0]        mag_q;

	logic [15:0] res_lin_q, res_ang_q;
	logic [2:0]  res_phase_q;
	logic        res_reached_q;

	logic        out_valid_q;
	logic [15:0] out_lin_q, out_ang_q;
	logic [4:0]  out_idx_q;
	logic [2:0]  out_phase_q;
	logic        out_reached_q;

	logic        in_acc, we, cdone, far, head_big, out_free;
	logic [31:0] rdata;
	logic [15:0] head, err;
	logic [16:0] mag;
	logic signed [17:0] mul_a, mul_b;
	logic signed [35:0] mul_p;
	logic [32:0] rnd;
	logic [16:0] r;
	logic [15:0] ang;
	whf_pkg::whf_cordic_req_t creq;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != whf_pkg::ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	// Table write on a load word; restart rewinds the list before storing.
	assign base = restart ? '0 : count_q;
	assign we   = in_acc && (opcode == whf_pkg::OP_LOAD) && (base < CW'(MAX_WAYPOINTS));

	whf_ram #(
		.WIDTH(32),
		.DEPTH(MAX_WAYPOINTS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(base[AW-1:0]),
		.wdata({pos_y, pos_x}),
		.raddr(idx_q[AW-1:0]),
		.rdata(rdata)
	);

	// Shared multiplier; each state picks its operands.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			whf_pkg::ST_SQX: begin
				mul_a = {dx_q[16], dx_q};
				mul_b = {dx_q[16], dx_q};
			end
			whf_pkg::ST_SQY: begin
				mul_a = {dy_q[16], dy_q};
				mul_b = {dy_q[16], dy_q};
			end
			whf_pkg::ST_TOL: begin
				mul_a = {2'b00, pos_tol_q};
				mul_b = {2'b00, pos_tol_q};
			end
			whf_pkg::ST_VX: begin
				mul_a = {{2{vx_q[15]}}, vx_q};
				mul_b = {{2{vx_q[15]}}, vx_q};
			end
			whf_pkg::ST_VY: begin
				mul_a = {{2{vy_q[15]}}, vy_q};
				mul_b = {{2{vy_q[15]}}, vy_q};
			end
			whf_pkg::ST_SET: begin
				mul_a = {2'b00, settle_q};
				mul_b = {2'b00, settle_q};
			end
			whf_pkg::ST_GAIN: begin
				mul_a = {2'b00, gain_q};
				mul_b = {1'b0, mag_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;
	assign far   = acc_q > mul_p[33:0];

	assign creq.start = (state_q == whf_pkg::ST_TOL) && far;
	assign creq.dx    = dx_q;
	assign creq.dy    = dy_q;

	whf_cordic #(
		.STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (creq),
		.done  (cdone),
		.head  (head)
	);

	// Heading error wraps to one turn; its magnitude can reach a half turn.
	assign err      = head - yaw_q;
	assign mag      = err[15] ? (17'd0 - {1'b1, err}) : {1'b0, err};
	assign head_big = mag > {2'b00, head_tol_q};

	// Turn rate rounds half away from zero, positive side saturates.
	assign rnd = {1'b0, mul_p[31:0]} + 33'h0_0000_8000;
	assign r   = rnd[32:16];
	always_comb begin
		if (err_neg_q) begin
			ang = 16'(17'd0 - r);
		end else if (r > 17'd32767) begin
			ang = 16'h7FFF;
		end else begin
			ang = r[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= whf_pkg::ST_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			pos_tol_q   <= 16'd100;
			head_tol_q  <= 15'd910;
			gain_q      <= 16'd26214;
			cruise_q    <= 16'd300;
			settle_q    <= 16'd1000;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					whf_pkg::REG_POS_TOL:  pos_tol_q  <= cfg_data;
					whf_pkg::REG_HEAD_TOL: head_tol_q <= cfg_data[14:0];
					whf_pkg::REG_GAIN:     gain_q     <= cfg_data;
					whf_pkg::REG_CRUISE:   cruise_q   <= cfg_data;
					whf_pkg::REG_SETTLE:   settle_q   <= cfg_data;
					default: ;
				endcase
			end

			if (state_q == whf_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				whf_pkg::ST_IDLE: begin
					if (in_acc && opcode == whf_pkg::OP_LOAD) begin
						if (restart) begin
							idx_q <= '0;
						end
						if (we) begin
							count_q <= base + 1'b1;
						end
					end else if (in_acc) begin
						if (count_q == '0 || idx_q >= count_q) begin
							state_q <= whf_pkg::ST_DONE;
						end else begin
							state_q <= whf_pkg::ST_DIFF;
						end
					end
				end
				whf_pkg::ST_DIFF: state_q <= whf_pkg::ST_SQX;
				whf_pkg::ST_SQX:  state_q <= whf_pkg::ST_SQY;
				whf_pkg::ST_SQY:  state_q <= whf_pkg::ST_TOL;
				whf_pkg::ST_TOL: begin
					state_q <= far ? whf_pkg::ST_CORD : whf_pkg::ST_VX;
				end
				whf_pkg::ST_CORD: begin
					if (cdone) begin
						state_q <= whf_pkg::ST_ERR;
					end
				end
				whf_pkg::ST_ERR: begin
					state_q <= head_big ? whf_pkg::ST_GAIN : whf_pkg::ST_DONE;
				end
				whf_pkg::ST_GAIN: state_q <= whf_pkg::ST_DONE;
				whf_pkg::ST_VX:   state_q <= whf_pkg::ST_VY;
				whf_pkg::ST_VY:   state_q <= whf_pkg::ST_SET;
				whf_pkg::ST_SET: begin
					if (acc_q <= mul_p[33:0]) begin
						idx_q <= idx_q + 1'b1;
					end
					state_q <= whf_pkg::ST_DONE;
				end
				whf_pkg::ST_DONE: begin
					if (out_free) begin
						state_q <= whf_pkg::ST_IDLE;
					end
				end
				default: state_q <= whf_pkg::ST_IDLE;
			endcase
		end
	end

	assign idx_ext = (CW + 5)'(idx_q);

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			px_q          <= pos_x;
			py_q          <= pos_y;
			yaw_q         <= yaw;
			vx_q          <= vel_x;
			vy_q          <= vel_y;
			res_lin_q     <= '0;
			res_ang_q     <= '0;
			res_reached_q <= 1'b0;
			res_phase_q   <= (count_q == '0) ? whf_pkg::PH_EMPTY : whf_pkg::PH_DONE;
		end
		case (state_q) inside
			whf_pkg::ST_DIFF: begin
				dx_q <= {rdata[15], rdata[15:0]} - {px_q[15], px_q};
				dy_q <= {rdata[31], rdata[31:16]} - {py_q[15], py_q};
			end
			whf_pkg::ST_SQX, whf_pkg::ST_VX: acc_q <= mul_p[33:0];
			whf_pkg::ST_SQY, whf_pkg::ST_VY: acc_q <= acc_q + mul_p[33:0];
			whf_pkg::ST_TOL: begin
				if (!far) begin
					res_phase_q <= whf_pkg::PH_STOP;
				end
			end
			whf_pkg::ST_ERR: begin
				err_neg_q <= err[15];
				mag_q     <= mag;
				if (head_big) begin
					res_phase_q <= whf_pkg::PH_TURN;
				end else begin
					res_phase_q <= whf_pkg::PH_DRIVE;
					res_lin_q   <= cruise_q;
				end
			end
			whf_pkg::ST_GAIN: res_ang_q <= ang;
			whf_pkg::ST_SET: res_reached_q <= (acc_q <= mul_p[33:0]);
			whf_pkg::ST_DONE: begin
				if (out_free) begin
					out_lin_q     <= res_lin_q;
					out_ang_q     <= res_ang_q;
					out_idx_q     <= idx_ext[4:0];
					out_phase_q   <= res_phase_q;
					out_reached_q <= res_reached_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid    = out_valid_q;
	assign linear_cmd   = out_lin_q;
	assign angular_cmd  = out_ang_q;
	assign target_index = out_idx_q;
	assign phase        = out_phase_q;
	assign reached      = out_reached_q;

endmodule

@@ rtl/core/whf_checker.sv @@
// Port-level checks for the waypoint heading follower, bound to the top level.
// Depends on whf_pkg for opcode and phase codes.
module whf_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               opcode,
	input logic               out_valid,
	input logic               out_stall,
	input logic [15:0]        linear_cmd,
	input logic signed [15:0] angular_cmd,
	input logic [4:0]         target_index,
	input logic [2:0]         phase,
	input logic               reached
);

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(linear_cmd) &&
		$stable(angular_cmd) && $stable(target_index) && $stable(phase) && $stable(reached))
		else $error("result word changed while stalled");

	// An odometry word always keeps the block busy on the next cycle.
	a_odom_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && opcode == whf_pkg::OP_ODOM |=> in_stall)
		else $error("odometry word accepted without going busy");

	a_reach_stop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reached |-> phase == whf_pkg::PH_STOP)
		else $error("waypoint reached outside the stopping phase");

	a_lin_drive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && linear_cmd != 16'd0 |-> phase == whf_pkg::PH_DRIVE && angular_cmd == 16'sd0)
		else $error("forward speed outside the driving phase");

	a_ang_turn: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && angular_cmd != 16'sd0 |-> phase == whf_pkg::PH_TURN && linear_cmd == 16'd0)
		else $error("turn rate outside the turning phase");

endmodule

bind waypoint_heading_follower whf_checker u_whf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.opcode      (opcode),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.linear_cmd  (linear_cmd),
	.angular_cmd (angular_cmd),
	.target_index(target_index),
	.phase       (phase),
	.reached     (reached)
);
